// File: hdl/grouped_bitmap_allocator_core_defines.svh
// Assertion macros shared by the allocator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef GROUPED_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define GROUPED_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

// Checked only outside reset
`define GBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included
`define GBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/gba_pkg.sv
// Shared constants, codes and controller/datapath interface types.
// No dependencies.
package gba_pkg;

    localparam int MAX_GROUPS      = 16;
    localparam int MAX_PER_GROUP   = 8192;
    localparam int WORD_BITS       = 32;
    localparam int WORDS_PER_GROUP = MAX_PER_GROUP / WORD_BITS;
    localparam int DEPTH           = MAX_GROUPS * WORDS_PER_GROUP;

    localparam int GRP_W  = $clog2(MAX_GROUPS);
    localparam int GCNT_W = GRP_W + 1;
    localparam int WIDX_W = $clog2(WORDS_PER_GROUP);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int ADDR_W = GRP_W + WIDX_W;

    // field widths
    localparam int PPG_W      = 14;
    localparam int GC_W       = 5;
    localparam int NUM_W      = 18;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int IN_W       = 24;
    localparam int OUT_W      = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLK_PER_G = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INO_PER_G = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRP_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLK = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        RES_OK     = 3'd0,
        RES_FULL   = 3'd1,
        RES_RANGE  = 3'd2,
        RES_FREED  = 3'd3,
        RES_OFF    = 3'd4
    } res_code_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_START,
        CMD_FAIL,
        CMD_GRP_NEXT,
        CMD_WORD_NEXT,
        CMD_READ,
        CMD_ALLOC_WR,
        CMD_DIV_STEP,
        CMD_FREE_WR,
        CMD_RESP
    } cmd_t;

    typedef struct packed {
        cmd_t      cmd;
        res_code_t code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic enabled;
        logic req_free;
        logic tot_full;
        logic grp_oob;
        logic grp_full;
        logic found;
        logic word_last;
        logic free_bad;
        logic div_done;
        logic bit_set;
        logic out_busy;
    } dp_stat_t;

endpackage

// File: hdl/gba_ctrl.sv
// Sequencer for the allocator: clearing pass, dispatch, scan, divide, respond.
// Depends on gba_pkg; drives gba_datapath through command and status structs.
module gba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  gba_pkg::dp_stat_t   stat,
    output gba_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_ALLOC_GRP, S_ALLOC_RD, S_ALLOC_EVAL,
        S_FREE_DIV, S_FREE_EVAL, S_RESP
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    // next state and command
    always_comb begin
        state_next = state_reg;
        cmd.cmd    = gba_pkg::CMD_NONE;
        cmd.code   = gba_pkg::RES_OK;
        case (state_reg)
            S_CLEAR: begin
                cmd.cmd = gba_pkg::CMD_CLEAR;
                if (stat.clear_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.cmd    = gba_pkg::CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!stat.enabled) begin
                    cmd.cmd    = gba_pkg::CMD_FAIL;
                    cmd.code   = gba_pkg::RES_OFF;
                    state_next = S_RESP;
                end else if (!stat.req_free) begin
                    if (stat.tot_full) begin
                        cmd.cmd    = gba_pkg::CMD_FAIL;
                        cmd.code   = gba_pkg::RES_FULL;
                        state_next = S_RESP;
                    end else begin
                        cmd.cmd    = gba_pkg::CMD_START;
                        state_next = S_ALLOC_GRP;
                    end
                end else if (stat.free_bad) begin
                    cmd.cmd    = gba_pkg::CMD_FAIL;
                    cmd.code   = gba_pkg::RES_RANGE;
                    state_next = S_RESP;
                end else begin
                    cmd.cmd    = gba_pkg::CMD_START;
                    state_next = S_FREE_DIV;
                end
            end
            S_ALLOC_GRP: begin
                if (stat.grp_oob) begin
                    cmd.cmd    = gba_pkg::CMD_FAIL;
                    cmd.code   = gba_pkg::RES_FULL;
                    state_next = S_RESP;
                end else if (stat.grp_full) begin
                    cmd.cmd = gba_pkg::CMD_GRP_NEXT;
                end else begin
                    state_next = S_ALLOC_RD;
                end
            end
            S_ALLOC_RD: begin
                cmd.cmd    = gba_pkg::CMD_READ;
                state_next = S_ALLOC_EVAL;
            end
            S_ALLOC_EVAL: begin
                if (stat.found) begin
                    cmd.cmd    = gba_pkg::CMD_ALLOC_WR;
                    state_next = S_RESP;
                end else if (stat.word_last) begin
                    cmd.cmd    = gba_pkg::CMD_GRP_NEXT;
                    state_next = S_ALLOC_GRP;
                end else begin
                    cmd.cmd    = gba_pkg::CMD_WORD_NEXT;
                    state_next = S_ALLOC_RD;
                end
            end
            S_FREE_DIV: begin
                if (stat.grp_oob) begin
                    cmd.cmd    = gba_pkg::CMD_FAIL;
                    cmd.code   = gba_pkg::RES_RANGE;
                    state_next = S_RESP;
                end else if (stat.div_done) begin
                    cmd.cmd    = gba_pkg::CMD_READ;
                    state_next = S_FREE_EVAL;
                end else begin
                    cmd.cmd = gba_pkg::CMD_DIV_STEP;
                end
            end
            S_FREE_EVAL: begin
                if (stat.bit_set) begin
                    cmd.cmd = gba_pkg::CMD_FREE_WR;
                end else begin
                    cmd.cmd  = gba_pkg::CMD_FAIL;
                    cmd.code = gba_pkg::RES_FREED;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!stat.out_busy) begin
                    cmd.cmd    = gba_pkg::CMD_RESP;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/gba_datapath.sv
// Allocator datapath: config registers, bitmap memories, counts, scan and
// divide registers, output word register. Depends on gba_pkg.
module gba_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gba_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [1:0]                          s_tuser,
    input  logic [gba_pkg::IN_W-1:0]            s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gba_pkg::OUT_W-1:0]           m_tdata,
    input  gba_pkg::ctrl_cmd_t                  cmd,
    output gba_pkg::dp_stat_t                   stat
);

    localparam int LIM_W = gba_pkg::PPG_W + 1;

    // configuration
    logic                          en_reg;
    logic [gba_pkg::PPG_W-1:0]     bpg_reg, ipg_reg;
    logic [gba_pkg::GC_W-1:0]      gcnt_reg;
    logic                          fdb_reg;

    // item and scan state
    logic                          req_reg, pool_reg;
    logic [gba_pkg::NUM_W-1:0]     num_reg, rem_reg, gbase_reg, result_reg;
    logic [gba_pkg::GCNT_W-1:0]    grp_reg;
    logic [gba_pkg::WIDX_W-1:0]    word_reg;
    gba_pkg::res_code_t            code_reg;
    logic [gba_pkg::ADDR_W-1:0]    clr_reg;
    logic                          out_valid_reg;
    logic [gba_pkg::OUT_W-1:0]     out_data_reg;

    // counts
    logic [gba_pkg::PPG_W-1:0]     blk_used_reg [gba_pkg::MAX_GROUPS];
    logic [gba_pkg::PPG_W-1:0]     ino_used_reg [gba_pkg::MAX_GROUPS];
    logic [gba_pkg::NUM_W-1:0]     blk_tot_reg, ino_tot_reg;

    // bitmap memories
    logic [gba_pkg::WORD_BITS-1:0] blk_mem [gba_pkg::DEPTH];
    logic [gba_pkg::WORD_BITS-1:0] ino_mem [gba_pkg::DEPTH];
    logic [gba_pkg::WORD_BITS-1:0] blk_q_reg, ino_q_reg;

    // derived values
    logic [gba_pkg::PPG_W-1:0]     ppg_raw, ppg, gused;
    logic [gba_pkg::GC_W-1:0]      gc;
    logic [gba_pkg::NUM_W-1:0]     base, tused, free_left;
    logic [gba_pkg::NUM_W:0]       cap;
    logic [gba_pkg::GRP_W-1:0]     gidx;
    logic [gba_pkg::ADDR_W-1:0]    addr;
    logic [gba_pkg::WORD_BITS-1:0] word_q, free_bits, wr_word;
    logic [LIM_W-1:0]              lim;
    logic [gba_pkg::BIT_W-1:0]     ffz, fbit;
    logic                          mem_we;

    assign ppg_raw = pool_reg ? ipg_reg : bpg_reg;
    assign ppg     = (ppg_raw > gba_pkg::PPG_W'(gba_pkg::MAX_PER_GROUP))
                     ? gba_pkg::PPG_W'(gba_pkg::MAX_PER_GROUP) : ppg_raw;
    assign gc      = (gcnt_reg > gba_pkg::GC_W'(gba_pkg::MAX_GROUPS))
                     ? gba_pkg::GC_W'(gba_pkg::MAX_GROUPS) : gcnt_reg;
    assign base    = pool_reg ? gba_pkg::NUM_W'(1) : gba_pkg::NUM_W'(fdb_reg);
    assign tused   = pool_reg ? ino_tot_reg : blk_tot_reg;
    assign cap     = (gba_pkg::NUM_W+1)'(gc) * (gba_pkg::NUM_W+1)'(ppg);
    assign free_left = (cap > {1'b0, tused})
                       ? gba_pkg::NUM_W'(cap - {1'b0, tused}) : '0;
    assign gidx    = grp_reg[gba_pkg::GRP_W-1:0];
    assign gused   = pool_reg ? ino_used_reg[gidx] : blk_used_reg[gidx];
    assign word_q  = pool_reg ? ino_q_reg : blk_q_reg;
    assign fbit    = rem_reg[gba_pkg::BIT_W-1:0];

    // word address: clearing sweep, free target, or scan position
    always_comb begin
        if (cmd.cmd == gba_pkg::CMD_CLEAR) begin
            addr = clr_reg;
        end else if (req_reg) begin
            addr = {gidx, rem_reg[gba_pkg::BIT_W+gba_pkg::WIDX_W-1:gba_pkg::BIT_W]};
        end else begin
            addr = {gidx, word_reg};
        end
    end

    // bits of the current word that lie inside the group, lowest clear one
    assign lim = LIM_W'(ppg) - LIM_W'({word_reg, {gba_pkg::BIT_W{1'b0}}});
    always_comb begin
        free_bits = '0;
        for (int k = 0; k < gba_pkg::WORD_BITS; k++) begin
            free_bits[k] = !word_q[k] && (LIM_W'(k) < lim);
        end
        ffz = '0;
        for (int k = gba_pkg::WORD_BITS - 1; k >= 0; k--) begin
            if (free_bits[k]) ffz = gba_pkg::BIT_W'(k);
        end
    end

    // memory write data
    always_comb begin
        mem_we  = 1'b0;
        wr_word = '0;
        case (cmd.cmd)
            gba_pkg::CMD_CLEAR: mem_we = 1'b1;
            gba_pkg::CMD_ALLOC_WR: begin
                mem_we  = 1'b1;
                wr_word = word_q | (gba_pkg::WORD_BITS'(1) << ffz);
            end
            gba_pkg::CMD_FREE_WR: begin
                mem_we  = 1'b1;
                wr_word = word_q & ~(gba_pkg::WORD_BITS'(1) << fbit);
            end
            default: mem_we = 1'b0;
        endcase
    end

    // bitmap memories: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we && (cmd.cmd == gba_pkg::CMD_CLEAR || !pool_reg)) blk_mem[addr] <= wr_word;
        if (mem_we && (cmd.cmd == gba_pkg::CMD_CLEAR || pool_reg))  ino_mem[addr] <= wr_word;
        if (cmd.cmd == gba_pkg::CMD_READ) begin
            blk_q_reg <= blk_mem[addr];
            ino_q_reg <= ino_mem[addr];
        end
    end

    // status to the controller
    always_comb begin
        stat.clear_done = (clr_reg == {gba_pkg::ADDR_W{1'b1}});
        stat.enabled    = en_reg;
        stat.req_free   = req_reg;
        stat.tot_full   = ({1'b0, tused} >= cap);
        stat.grp_oob    = (grp_reg >= gba_pkg::GCNT_W'(gc));
        stat.grp_full   = (gused >= ppg);
        stat.found      = |free_bits;
        stat.word_last  = (lim <= LIM_W'(gba_pkg::WORD_BITS));
        stat.free_bad   = (num_reg == '0) || (num_reg < base) || (ppg == '0);
        stat.div_done   = (rem_reg < gba_pkg::NUM_W'(ppg));
        stat.bit_set    = word_q[fbit];
        stat.out_busy   = out_valid_reg && !m_tready;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg   <= 1'b0;
            bpg_reg  <= gba_pkg::PPG_W'(8192);
            ipg_reg  <= gba_pkg::PPG_W'(2048);
            gcnt_reg <= gba_pkg::GC_W'(1);
            fdb_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gba_pkg::REG_ENABLED:   en_reg   <= cfg_wdata[0];
                gba_pkg::REG_BLK_PER_G: bpg_reg  <= cfg_wdata;
                gba_pkg::REG_INO_PER_G: ipg_reg  <= cfg_wdata;
                gba_pkg::REG_GRP_COUNT: gcnt_reg <= cfg_wdata[gba_pkg::GC_W-1:0];
                gba_pkg::REG_FIRST_BLK: fdb_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // item, scan and divide registers
    always_ff @(posedge aclk) begin
        case (cmd.cmd)
            gba_pkg::CMD_LOAD: begin
                req_reg    <= s_tuser[0];
                pool_reg   <= s_tuser[1];
                num_reg    <= s_tdata[gba_pkg::NUM_W-1:0];
                result_reg <= '0;
                code_reg   <= gba_pkg::RES_OK;
            end
            gba_pkg::CMD_START: begin
                grp_reg   <= '0;
                gbase_reg <= '0;
                word_reg  <= '0;
                rem_reg   <= num_reg - base;
            end
            gba_pkg::CMD_FAIL: code_reg <= cmd.code;
            gba_pkg::CMD_GRP_NEXT: begin
                grp_reg   <= grp_reg + 1'b1;
                gbase_reg <= gbase_reg + gba_pkg::NUM_W'(ppg);
                word_reg  <= '0;
            end
            gba_pkg::CMD_WORD_NEXT: word_reg <= word_reg + 1'b1;
            gba_pkg::CMD_DIV_STEP: begin
                rem_reg <= rem_reg - gba_pkg::NUM_W'(ppg);
                grp_reg <= grp_reg + 1'b1;
            end
            gba_pkg::CMD_ALLOC_WR:
                result_reg <= gbase_reg + gba_pkg::NUM_W'({word_reg, ffz}) + base;
            default: ;
        endcase
    end

    // use counts and clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            blk_tot_reg <= '0;
            ino_tot_reg <= '0;
            for (int g = 0; g < gba_pkg::MAX_GROUPS; g++) begin
                blk_used_reg[g] <= '0;
                ino_used_reg[g] <= '0;
            end
        end else begin
            if (cmd.cmd == gba_pkg::CMD_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cmd.cmd == gba_pkg::CMD_ALLOC_WR) begin
                if (pool_reg) begin
                    ino_used_reg[gidx] <= ino_used_reg[gidx] + 1'b1;
                    ino_tot_reg        <= ino_tot_reg + 1'b1;
                end else begin
                    blk_used_reg[gidx] <= blk_used_reg[gidx] + 1'b1;
                    blk_tot_reg        <= blk_tot_reg + 1'b1;
                end
            end
            // counts saturate at zero on free
            if (cmd.cmd == gba_pkg::CMD_FREE_WR) begin
                if (pool_reg) begin
                    if (ino_used_reg[gidx] != '0) ino_used_reg[gidx] <= ino_used_reg[gidx] - 1'b1;
                    if (ino_tot_reg != '0) ino_tot_reg <= ino_tot_reg - 1'b1;
                end else begin
                    if (blk_used_reg[gidx] != '0) blk_used_reg[gidx] <= blk_used_reg[gidx] - 1'b1;
                    if (blk_tot_reg != '0) blk_tot_reg <= blk_tot_reg - 1'b1;
                end
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.cmd == gba_pkg::CMD_RESP) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.cmd == gba_pkg::CMD_RESP) begin
            out_data_reg <= {1'b0, free_left, code_reg, result_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: hdl/grouped_bitmap_allocator_core.sv
// Top level of the grouped bitmap allocator.
// Depends on gba_pkg, gba_ctrl and gba_datapath.
//
// Two first-fit bitmap pools (blocks and inodes) of up to 16 groups of up to
// 8192 entries, held in two 4096 x 32 memories. After reset a clearing pass
// writes every word to zero, during which s_tready is low (configuration
// writes are taken). One request is handled at a time; a new one is taken
// while the previous result still waits on the m_ side. An allocate skips
// groups whose count shows them full and reads the memory of the others word
// by word in the scan (one read port, one word per read). A free divides the
// number by the entries per group by repeated subtraction, one group per
// step, then reads the word and clears the entry's bit if it is set. Requests
// refused at dispatch answer without a scan; a free whose group is out of
// range answers after the divide steps.
module grouped_bitmap_allocator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gba_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gba_pkg::IN_W-1:0]            s_tdata,   // number[17:0], zero pad
    input  logic [1:0]                          s_tuser,   // req_type[0], pool[1]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gba_pkg::OUT_W-1:0]           m_tdata    // alloc_number[17:0],
                                                           // status[20:18],
                                                           // free_left[38:21], pad
);

    gba_pkg::ctrl_cmd_t cmd;
    gba_pkg::dp_stat_t  stat;

    gba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gba_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: hdl/gba_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on gba_pkg and grouped_bitmap_allocator_core_defines.svh.
`include "grouped_bitmap_allocator_core_defines.svh"

module gba_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wr_en,
    input logic [gba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [gba_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [gba_pkg::IN_W-1:0]         s_tdata,
    input logic [1:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [gba_pkg::OUT_W-1:0]        m_tdata
);

    // result word fields
    gba_pkg::res_code_t             out_code;
    logic [gba_pkg::NUM_W-1:0]      out_num;

    assign out_code = gba_pkg::res_code_t'(m_tdata[20:18]);
    assign out_num  = m_tdata[gba_pkg::NUM_W-1:0];

    // held result stays offered
    `GBA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `GBA_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")
    // status code in range, and a failure carries no number
    `GBA_ASSERT(a_code_range, m_tvalid |-> (out_code <= gba_pkg::RES_OFF), "bad status")
    `GBA_ASSERT(a_fail_zero, m_tvalid && (out_code != gba_pkg::RES_OK) |-> (out_num == '0), "fail number")
    // reset empties the output and blocks input
    `GBA_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid && !s_tready, "not idle after reset")

endmodule

bind grouped_bitmap_allocator_core gba_checker u_gba_checker (.*);

// File: dv/tb_grouped_bitmap_allocator_core.sv
// Self-checking bench for grouped_bitmap_allocator_core: predicts allocate and
// free results for both pools and compares each result word field by field.
// Depends on gba_pkg and the allocator RTL.
module tb_grouped_bitmap_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      req_free;
        logic                      inode;
        logic [gba_pkg::NUM_W-1:0] number;
    } alloc_req_t;

    // packed from the top bit down: free_left, status, alloc_number
    typedef struct packed {
        logic [gba_pkg::NUM_W-1:0] free_left;
        gba_pkg::res_code_t        code;
        logic [gba_pkg::NUM_W-1:0] number;
    } alloc_res_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [gba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gba_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gba_pkg::IN_W-1:0]       s_tdata = '0;
    logic [1:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [gba_pkg::OUT_W-1:0]      m_tdata;

    grouped_bitmap_allocator_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow state of both pools: [0] blocks, [1] inodes
    bit        used_map [2][gba_pkg::MAX_GROUPS*gba_pkg::MAX_PER_GROUP];
    int        grp_used [2][gba_pkg::MAX_GROUPS];
    int        tot_used [2];
    bit        cfg_en    = 0;
    int        cfg_bpg   = 8192;
    int        cfg_ipg   = 2048;
    int        cfg_gc    = 1;
    int        cfg_fdb   = 1;

    alloc_req_t req_q [$];
    alloc_res_t res_q [$];
    int         n_errors = 0;
    bit         send_hold = 0;

    // Apply one request to the shadow pools and return the expected result
    function automatic alloc_res_t predict_alloc(alloc_req_t r);
        alloc_res_t res;
        int p, ppg, gc, base, cap, adj, g, i, b;
        bit found;
        p    = r.inode;
        ppg  = p ? cfg_ipg : cfg_bpg;
        if (ppg > gba_pkg::MAX_PER_GROUP) ppg = gba_pkg::MAX_PER_GROUP;
        gc   = cfg_gc > gba_pkg::MAX_GROUPS ? gba_pkg::MAX_GROUPS : cfg_gc;
        base = p ? 1 : cfg_fdb;
        cap  = gc * ppg;
        found = 0;
        res.number = '0;
        res.code = gba_pkg::RES_OK;
        if (!cfg_en) begin
            res.code = gba_pkg::RES_OFF;
        end else if (!r.req_free) begin
            res.code = gba_pkg::RES_FULL;
            if (tot_used[p] < cap) begin
                for (g = 0; g < gc && !found; g++) begin
                    if (grp_used[p][g] >= ppg) continue;
                    for (i = 0; i < ppg; i++) begin
                        b = g * gba_pkg::MAX_PER_GROUP + i;
                        if (!used_map[p][b]) begin
                            used_map[p][b] = 1;
                            grp_used[p][g]++;
                            tot_used[p]++;
                            res.number = gba_pkg::NUM_W'(g * ppg + i + base);
                            res.code = gba_pkg::RES_OK;
                            found = 1;
                            break;
                        end
                    end
                end
            end
        end else begin
            if (r.number == 0 || int'(r.number) < base || ppg == 0) begin
                res.code = gba_pkg::RES_RANGE;
            end else begin
                adj = int'(r.number) - base;
                g = adj / ppg;
                i = adj % ppg;
                if (g >= gc) begin
                    res.code = gba_pkg::RES_RANGE;
                end else begin
                    b = g * gba_pkg::MAX_PER_GROUP + i;
                    if (!used_map[p][b]) begin
                        res.code = gba_pkg::RES_FREED;
                    end else begin
                        used_map[p][b] = 0;
                        if (grp_used[p][g] > 0) grp_used[p][g]--;
                        if (tot_used[p] > 0) tot_used[p]--;
                    end
                end
            end
        end
        res.free_left = gba_pkg::NUM_W'(cap > tot_used[p] ? cap - tot_used[p] : 0);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one, often none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: feeds words from the pending queue with random gaps
    int gap_cnt = 0;
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            res_q.push_back(predict_alloc(req_q.pop_front()));
        end
        if (!(s_tvalid && !s_tready)) begin
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                s_tvalid <= 1'b0;
            end else if (req_q.size() > 0 && !send_hold && aresetn) begin
                s_tvalid <= 1'b1;
                s_tdata  <= gba_pkg::IN_W'(req_q[0].number);
                s_tuser  <= {req_q[0].inode, req_q[0].req_free};
                gap_cnt  <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and result checking
    int rdy_gap = 0;
    always @(posedge aclk) begin
        alloc_res_t got, want;
        if (rdy_gap > 0) begin
            rdy_gap  <= rdy_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30) rdy_gap <= pick_gap();
        end
        if (m_tvalid && m_tready) begin
            got = alloc_res_t'(m_tdata[38:0]);
            if (res_q.size() == 0) begin
                $error("result word with no request pending");
                n_errors++;
            end else begin
                want = res_q.pop_front();
                if (got.number !== want.number) begin
                    $error("alloc_number expected %0d got %0d", want.number, got.number);
                    n_errors++;
                end
                if (got.code !== want.code) begin
                    $error("status expected %0d got %0d", want.code, got.code);
                    n_errors++;
                end
                if (got.free_left !== want.free_left) begin
                    $error("free_left expected %0d got %0d", want.free_left, got.free_left);
                    n_errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [gba_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= gba_pkg::CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            gba_pkg::REG_ENABLED:   cfg_en  = val & 1;
            gba_pkg::REG_BLK_PER_G: cfg_bpg = val & 16'h3fff;
            gba_pkg::REG_INO_PER_G: cfg_ipg = val & 16'h3fff;
            gba_pkg::REG_GRP_COUNT: cfg_gc  = val & 31;
            gba_pkg::REG_FIRST_BLK: cfg_fdb = val & 1;
            default: ;
        endcase
    endtask

    // Wait until every word is out and the block is quiet
    task automatic drain();
        while (req_q.size() > 0 || s_tvalid || res_q.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Let a word through, then hold the sender until every result is back
    task automatic drain_hold();
        while (res_q.size() == 0) @(posedge aclk);
        send_hold <= 1'b1;
        @(posedge aclk);
        while (res_q.size() > 0 || s_tvalid) @(posedge aclk);
        send_hold <= 1'b0;
        drain();
    endtask

    function automatic void push_req(bit fr, bit ino, int num);
        alloc_req_t r;
        r.req_free = fr;
        r.inode = ino;
        r.number = gba_pkg::NUM_W'(num);
        req_q.push_back(r);
    endfunction

    // Random phase: alloc/free mix, frees aimed mostly inside the configured range
    task automatic random_phase(int n);
        int k, p, ppg, base, num;
        for (k = 0; k < n; k++) begin
            p = $urandom_range(0, 1);
            ppg = p ? cfg_ipg : cfg_bpg;
            base = p ? 1 : cfg_fdb;
            if ($urandom_range(0, 9) < 5) begin
                push_req(0, p, $urandom_range(0, 18'h3ffff));
            end else if ($urandom_range(0, 9) < 7) begin
                num = base + $urandom_range(0, cfg_gc * ppg + 1);
                push_req(1, p, num);
            end else begin
                push_req(1, p, $urandom_range(0, 18'h3ffff));
            end
        end
    endtask

    initial begin
        int ph;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Disabled: everything fails
        push_req(0, 0, 0);
        push_req(1, 1, 5);
        drain();

        // Tiny pools to reach full, double free and range cases
        write_reg(gba_pkg::REG_ENABLED, 1);
        write_reg(gba_pkg::REG_BLK_PER_G, 3);
        write_reg(gba_pkg::REG_INO_PER_G, 1);
        write_reg(gba_pkg::REG_GRP_COUNT, 2);
        write_reg(gba_pkg::REG_FIRST_BLK, 0);
        repeat (7) push_req(0, 0, 0);
        repeat (3) push_req(0, 1, 0);
        push_req(1, 0, 0);
        push_req(1, 0, 3);
        push_req(1, 0, 3);
        push_req(1, 0, 6);
        push_req(1, 0, 18'h3ffff);
        push_req(1, 1, 0);
        push_req(1, 1, 2);
        push_req(1, 1, 3);
        push_req(0, 0, 18'h3ffff);
        drain();

        // Pause sender until all results arrive, with the queue non-empty
        repeat (4) push_req(0, 1, 0);
        drain_hold();

        // Zero-size pools and oversized group count
        write_reg(gba_pkg::REG_GRP_COUNT, 0);
        push_req(0, 0, 0);
        push_req(1, 1, 1);
        drain();
        write_reg(gba_pkg::REG_GRP_COUNT, 31);
        write_reg(gba_pkg::REG_BLK_PER_G, 0);
        write_reg(gba_pkg::REG_INO_PER_G, 16383);
        push_req(0, 0, 0);
        push_req(1, 0, 1);
        push_req(0, 1, 0);
        push_req(1, 1, 131073);
        drain();
        write_reg(gba_pkg::REG_ENABLED, 0);
        push_req(1, 1, 1);
        drain();
        write_reg(gba_pkg::REG_ENABLED, 1);

        // Random phases over several small settings
        for (ph = 0; ph < 7; ph++) begin
            write_reg(gba_pkg::REG_BLK_PER_G, $urandom_range(1, 70));
            write_reg(gba_pkg::REG_INO_PER_G, $urandom_range(1, 40));
            write_reg(gba_pkg::REG_GRP_COUNT, $urandom_range(1, 16));
            write_reg(gba_pkg::REG_FIRST_BLK, $urandom_range(0, 1));
            random_phase(240);
            drain();
        end
        write_reg(gba_pkg::REG_BLK_PER_G, 8192);
        write_reg(gba_pkg::REG_GRP_COUNT, 1);
        random_phase(60);
        drain();

        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end
endmodule
